// ===== design/psgc_pkg.sv =====
`default_nettype none

package psgc_pkg;

   localparam int SAMPLE_BITS_DEFAULT = 24;

   // Blend weight scale (Q0.16 one) and rounding half.
   localparam logic [16:0] BLEND_ONE  = 17'h10000;
   localparam logic [16:0] BLEND_HALF = 17'h08000;

   // Register indexes
   localparam logic CSR_SMOOTH = 1'b0;
   localparam logic CSR_SELECT = 1'b1;

   localparam int STEP_BITS = 3;

   typedef enum logic [2:0] {
      OP_IDLE,
      OP_MAG,
      OP_MUL_PEAK,
      OP_MUL_MOD,
      OP_BLEND,
      OP_MUL_P,
      OP_SQRT,
      OP_EMIT
   } op_type;

   typedef enum logic [1:0] {
      WAIT_NONE,
      WAIT_IN,
      WAIT_OUT
   } wait_type;

   typedef enum logic [1:0] {
      JMP_NEXT,
      JMP_ALWAYS,
      JMP_LOOP
   } jump_type;

   typedef struct packed {
      op_type                 op;
      wait_type               wait_kind;
      jump_type               jump;
      logic [STEP_BITS-1:0]   target;
   } seq_ctrl_type;

   typedef struct packed {
      logic in_fire;
      logic out_busy;
      logic loop_done;
   } seq_status_type;

   // Microprogram: one control word per step.
   function automatic seq_ctrl_type rom_word(input logic [STEP_BITS-1:0] step);
      seq_ctrl_type w;
      w = '{op: OP_IDLE, wait_kind: WAIT_NONE, jump: JMP_NEXT, target: '0};
      case (step)
         3'd0: w = '{op: OP_IDLE,     wait_kind: WAIT_IN,   jump: JMP_NEXT,   target: 3'd0};
         3'd1: w = '{op: OP_MAG,      wait_kind: WAIT_NONE, jump: JMP_NEXT,   target: 3'd0};
         3'd2: w = '{op: OP_MUL_PEAK, wait_kind: WAIT_NONE, jump: JMP_NEXT,   target: 3'd0};
         3'd3: w = '{op: OP_MUL_MOD,  wait_kind: WAIT_NONE, jump: JMP_NEXT,   target: 3'd0};
         3'd4: w = '{op: OP_BLEND,    wait_kind: WAIT_NONE, jump: JMP_NEXT,   target: 3'd0};
         3'd5: w = '{op: OP_MUL_P,    wait_kind: WAIT_NONE, jump: JMP_NEXT,   target: 3'd0};
         3'd6: w = '{op: OP_SQRT,     wait_kind: WAIT_NONE, jump: JMP_LOOP,   target: 3'd6};
         3'd7: w = '{op: OP_EMIT,     wait_kind: WAIT_OUT,  jump: JMP_ALWAYS, target: 3'd0};
         default: w = '{op: OP_IDLE, wait_kind: WAIT_IN, jump: JMP_ALWAYS, target: 3'd0};
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// ===== design/peak_smoothed_geometric_crossmod.sv =====
`default_nettype none
// Each frame is stepped through magnitude, multiply, blend, multiply, square root and
// emit steps; the square root loop yields one bit per cycle. One frame is in flight
// at a time: the wait step accepts the next frame after the previous one is emitted.
// Reset (synchronous, active high) clears the held peak, both registers and
// the sequencer; the output register comes up empty.

module peak_smoothed_geometric_crossmod #(
   parameter  int SAMPLE_BITS = psgc_pkg::SAMPLE_BITS_DEFAULT,
   localparam int ReqW        = ((2 * SAMPLE_BITS + 7) / 8) * 8,
   localparam int RspW        = ((SAMPLE_BITS + 7) / 8) * 8
) (
   input  wire logic            clock,
   input  wire logic            reset,
   // input frame channel
   input  wire logic            req_tvalid,
   output logic                 req_tready,
   input  wire logic [ReqW-1:0] req_tdata,   // left_sample, right_sample
   // result channel
   output logic                 rsp_tvalid,
   input  wire logic            rsp_tready,
   output logic [RspW-1:0]      rsp_tdata,   // out_sample
   // register write port
   input  wire logic            csr_we,
   input  wire logic            csr_index,
   input  wire logic [15:0]     csr_wdata
);
   import psgc_pkg::*;

   localparam int S    = SAMPLE_BITS;
   localparam int MulA = (S > 17) ? S : 17;   // shared multiplier A width
   localparam int ProdW = MulA + S;
   localparam int AccW = S + 17;             // blend terms
   localparam int RemW = S + 3;              // sqrt partial remainder
   localparam int CntW = $clog2(S);

   seq_ctrl_type   ctrl;
   seq_status_type status;

   psgc_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   // configuration
   logic [15:0]     smooth_ff;
   logic            select_ff;

   // datapath
   logic [S-1:0]    left_ff, left_in, right_ff, right_in;
   logic [S-1:0]    peak_ff, peak_in;
   logic [S-1:0]    cmag_ff, cmag_in, mod_ff, mod_in, meff_ff, meff_in;
   logic            cneg_ff, cneg_in;
   logic [AccW-1:0] acc_ff, acc_in;
   logic [ProdW-1:0] prod_ff, prod_in;
   logic [2*S-1:0]  rad_ff, rad_in;
   logic [RemW-1:0] rem_ff, rem_in;
   logic [S-1:0]    root_ff, root_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic [S-1:0]    rsp_data_ff, rsp_data_in;
   logic            rsp_valid_ff, rsp_valid_in;

   logic            in_fire, out_busy;
   logic [S-1:0]    lmag, rmag, new_mod;
   logic [MulA-1:0] mul_a;
   logic [S-1:0]    mul_b;
   logic [ProdW-1:0] product;
   logic [AccW:0]   blend_sum;
   logic [RemW-1:0] rem_t, trial;
   logic            take;

   // no transfer is taken while reset is held
   assign req_tready = (ctrl.wait_kind == WAIT_IN) && !reset;
   assign in_fire    = req_tvalid && req_tready;
   assign out_busy   = rsp_valid_ff && !rsp_tready;

   assign status.in_fire   = in_fire;
   assign status.out_busy  = out_busy;
   assign status.loop_done = (cnt_ff == '0);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RspW'(rsp_data_ff);

   // exact magnitudes; the most negative code maps to 2^(S-1)
   assign lmag = left_ff[S-1]  ? (~left_ff + 1'b1)  : left_ff;
   assign rmag = right_ff[S-1] ? (~right_ff + 1'b1) : right_ff;
   assign new_mod = select_ff ? lmag : rmag;

   // shared multiplier, operands picked by the current micro-op
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (ctrl.op)
         OP_MUL_PEAK: begin
            mul_a = MulA'(smooth_ff);
            mul_b = peak_ff;
         end
         OP_MUL_MOD: begin
            mul_a = MulA'(BLEND_ONE - {1'b0, smooth_ff});
            mul_b = mod_ff;
         end
         OP_MUL_P: begin
            mul_a = MulA'(meff_ff);
            mul_b = cmag_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign product   = ProdW'(mul_a) * ProdW'(mul_b);
   assign blend_sum = (AccW + 1)'(acc_ff) + (AccW + 1)'(prod_ff[AccW-1:0])
                    + (AccW + 1)'(BLEND_HALF);

   // restoring square root, one result bit per cycle
   assign rem_t = {rem_ff[RemW-3:0], rad_ff[2*S-1 -: 2]};
   assign trial = {1'b0, root_ff, 2'b01};
   assign take  = (rem_t >= trial);

   always_comb begin
      left_in      = left_ff;
      right_in     = right_ff;
      peak_in      = peak_ff;
      cmag_in      = cmag_ff;
      mod_in       = mod_ff;
      cneg_in      = cneg_ff;
      meff_in      = meff_ff;
      acc_in       = acc_ff;
      prod_in      = prod_ff;
      rad_in       = rad_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      cnt_in       = cnt_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      case (ctrl.op)
         OP_IDLE: begin
            if (in_fire) begin
               left_in  = req_tdata[S-1:0];
               right_in = req_tdata[2*S-1:S];
            end
         end
         OP_MAG: begin
            mod_in  = new_mod;
            cmag_in = select_ff ? rmag : lmag;
            cneg_in = select_ff ? right_ff[S-1] : left_ff[S-1];
            // peak only ever rises
            if (peak_ff < new_mod) begin
               peak_in = new_mod;
            end
         end
         OP_MUL_PEAK: acc_in  = product[AccW-1:0];
         OP_MUL_MOD:  prod_in = product;
         OP_BLEND:    meff_in = blend_sum[S+15:16];
         OP_MUL_P: begin
            rad_in  = product[2*S-1:0];
            rem_in  = '0;
            root_in = '0;
            cnt_in  = CntW'(S - 1);
         end
         OP_SQRT: begin
            rad_in  = {rad_ff[2*S-3:0], 2'b00};
            rem_in  = take ? (rem_t - trial) : rem_t;
            root_in = {root_ff[S-2:0], take};
            if (cnt_ff != '0) begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         OP_EMIT: begin
            if (!out_busy) begin
               rsp_valid_in = 1'b1;
               if (root_ff == '0) begin
                  rsp_data_in = '0;
               end else if (cneg_ff) begin
                  rsp_data_in = ~root_ff + 1'b1;
               end else if (root_ff[S-1]) begin
                  // positive full scale saturates
                  rsp_data_in = {1'b0, {(S - 1){1'b1}}};
               end else begin
                  rsp_data_in = root_ff;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         smooth_ff    <= '0;
         select_ff    <= 1'b0;
         peak_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we && (csr_index == CSR_SMOOTH)) begin
            smooth_ff <= csr_wdata;
         end
         if (csr_we && (csr_index == CSR_SELECT)) begin
            select_ff <= csr_wdata[0];
         end
         peak_ff      <= peak_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff     <= left_in;
      right_ff    <= right_in;
      cmag_ff     <= cmag_in;
      mod_ff      <= mod_in;
      cneg_ff     <= cneg_in;
      meff_ff     <= meff_in;
      acc_ff      <= acc_in;
      prod_ff     <= prod_in;
      rad_ff      <= rad_in;
      rem_ff      <= rem_in;
      root_ff     <= root_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

// ===== design/psgc_seq.sv =====
`default_nettype none

module psgc_seq (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire psgc_pkg::seq_status_type status,
   output psgc_pkg::seq_ctrl_type        ctrl
);
   import psgc_pkg::*;

   logic [STEP_BITS-1:0] step_ff, step_in;
   logic                 stall;

   assign ctrl = rom_word(step_ff);

   always_comb begin
      stall = ((ctrl.wait_kind == WAIT_IN) && !status.in_fire) ||
              ((ctrl.wait_kind == WAIT_OUT) && status.out_busy);
      step_in = step_ff;
      if (!stall) begin
         case (ctrl.jump)
            JMP_NEXT:   step_in = step_ff + 1'b1;
            JMP_ALWAYS: step_in = ctrl.target;
            JMP_LOOP:   step_in = status.loop_done ? step_ff + 1'b1 : ctrl.target;
            default:    step_in = ctrl.target;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

`default_nettype wire
